### design/mt64_pkg.sv
// Shared types, constants and functions for the 64-bit Mersenne Twister generator.
// No dependencies; every other design file imports this package.
`default_nettype none

package mt64_pkg;

	localparam int STATE_DEPTH  = 312;
	localparam int SHIFT_OFFSET = 156;
	localparam int IDX_W        = $clog2(STATE_DEPTH + 1);
	localparam int ADDR_W       = $clog2(STATE_DEPTH);

	localparam logic [IDX_W-1:0]  IDX_DEPTH = IDX_W'(STATE_DEPTH);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STATE_DEPTH - 1);
	localparam logic [ADDR_W-1:0] ADDR_OFF  = ADDR_W'(SHIFT_OFFSET);

	localparam logic [63:0] TWIST_XOR = 64'hb502_6f5a_a966_19e9;
	localparam logic [63:0] TEMPER_D  = 64'h5555_5555_5555_5555;
	localparam logic [63:0] TEMPER_B  = 64'h71d6_7fff_eda6_0000;
	localparam logic [63:0] TEMPER_C  = 64'hfff7_eee0_0000_0000;
	localparam logic [63:0] SEED_MULT = 64'h5851_f42d_4c95_7f2d;
	localparam int TEMPER_U  = 29;
	localparam int TEMPER_S  = 17;
	localparam int TEMPER_T  = 37;
	localparam int TEMPER_L  = 43;
	localparam int SPLIT_BIT = 31;
	localparam int SEED_SHR  = 62;

	localparam logic [63:0] LOW_PART_MASK  = (64'd1 << SPLIT_BIT) - 64'd1;
	localparam logic [63:0] HIGH_PART_MASK = ~LOW_PART_MASK;

	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [63:0] seed_value;
	} req_t;

	typedef struct packed {
		logic [63:0] random_word;
		logic        unseeded;
	} rsp_t;

	typedef enum logic [1:0] {
		ENG_NONE,
		ENG_SEED,
		ENG_TWIST,
		ENG_READ
	} eng_op_t;

	typedef struct packed {
		eng_op_t             op;
		logic [ADDR_W-1:0]   addr;
	} eng_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] rdata;
	} eng_sts_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_SEED_MUL,
		E_SEED_WR,
		E_TW_RD0,
		E_TW_RD1,
		E_TW_WR,
		E_RD
	} eng_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_SEED,
		T_TWIST,
		T_RD_ISSUE,
		T_READ,
		T_OUT
	} top_state_t;

	function automatic logic [63:0] seed_mix(input logic [63:0] v);
		return v ^ (v >> SEED_SHR);
	endfunction

	function automatic logic [63:0] twist_word(input logic [63:0] cur, input logic [63:0] nxt,
			input logic [63:0] far);
		logic [63:0] mix;
		logic [63:0] shifted;
		mix     = (cur & HIGH_PART_MASK) | (nxt & LOW_PART_MASK);
		shifted = mix >> 1;
		if (mix[0]) begin
			shifted = shifted ^ TWIST_XOR;
		end
		return far ^ shifted;
	endfunction

	function automatic logic [63:0] temper(input logic [63:0] y_in);
		logic [63:0] y;
		y = y_in;
		y = y ^ ((y >> TEMPER_U) & TEMPER_D);
		y = y ^ ((y << TEMPER_S) & TEMPER_B);
		y = y ^ ((y << TEMPER_T) & TEMPER_C);
		y = y ^ (y >> TEMPER_L);
		return y;
	endfunction

endpackage

`default_nettype wire

### design/mt64_engine.sv
// State store and sequencer for seeding and twisting, with one shared 32x32 multiplier.
// Depends on mt64_pkg.
`default_nettype none

module mt64_engine
	import mt64_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire eng_cmd_t cmd,
	input  wire logic [63:0] seed,
	output eng_sts_t      sts
);

	logic [63:0] mem [STATE_DEPTH];

	eng_state_t        state_q, state_d;
	logic [ADDR_W-1:0] k_q, k_d;
	logic [1:0]        ph_q, ph_d;
	logic [63:0]       x_q, x_d;
	logic [63:0]       acc_q, acc_d;
	logic [63:0]       hi_q, hi_d;
	logic [63:0]       rdata_a_q, rdata_b_q;
	logic [ADDR_W-1:0] raddr_a, raddr_b, waddr, partner;
	logic              we;
	logic [63:0]       wdata;
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       prod;

	assign prod = 64'(mul_a) * 64'(mul_b);

	assign partner = (k_q < ADDR_OFF) ? k_q + ADDR_OFF : k_q - ADDR_OFF;

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		ph_d      = ph_q;
		x_d       = x_q;
		acc_d     = acc_q;
		hi_d      = hi_q;
		raddr_a   = k_q;
		raddr_b   = partner;
		we        = 1'b0;
		waddr     = k_q;
		wdata     = acc_q;
		mul_a     = x_q[31:0];
		mul_b     = SEED_MULT[31:0];
		sts.done  = 1'b0;
		sts.rdata = rdata_a_q;
		unique case (state_q)
			E_IDLE: begin
				unique case (cmd.op)
					ENG_SEED: begin
						we      = 1'b1;
						waddr   = '0;
						wdata   = seed;
						x_d     = seed_mix(seed);
						k_d     = ADDR_W'(1);
						ph_d    = 2'd0;
						state_d = E_SEED_MUL;
					end
					ENG_TWIST: begin
						k_d     = '0;
						state_d = E_TW_RD0;
					end
					ENG_READ: begin
						raddr_a = cmd.addr;
						state_d = E_RD;
					end
					default: begin
					end
				endcase
			end
			E_SEED_MUL: begin
				// The product modulo 2^64 is built from three 32x32 partial products.
				case (ph_q)
					2'd0: begin
						acc_d = prod + 64'(k_q);
						ph_d  = 2'd1;
					end
					2'd1: begin
						mul_a = x_q[63:32];
						acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
						ph_d  = 2'd2;
					end
					default: begin
						mul_b   = SEED_MULT[63:32];
						acc_d   = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
						state_d = E_SEED_WR;
					end
				endcase
			end
			E_SEED_WR: begin
				we   = 1'b1;
				x_d  = seed_mix(acc_q);
				ph_d = 2'd0;
				if (k_q == ADDR_LAST) begin
					sts.done = 1'b1;
					state_d  = E_IDLE;
				end else begin
					k_d     = k_q + ADDR_W'(1);
					state_d = E_SEED_MUL;
				end
			end
			E_TW_RD0: begin
				state_d = E_TW_RD1;
			end
			E_TW_RD1: begin
				// The last word pairs with word 0, which has already been regenerated.
				raddr_a = (k_q == ADDR_LAST) ? '0 : k_q + ADDR_W'(1);
				hi_d    = rdata_a_q;
				state_d = E_TW_WR;
			end
			E_TW_WR: begin
				we    = 1'b1;
				wdata = twist_word(hi_q, rdata_a_q, rdata_b_q);
				if (k_q == ADDR_LAST) begin
					sts.done = 1'b1;
					state_d  = E_IDLE;
				end else begin
					k_d     = k_q + ADDR_W'(1);
					state_d = E_TW_RD0;
				end
			end
			E_RD: begin
				sts.done = 1'b1;
				state_d  = E_IDLE;
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q   <= k_d;
		ph_q  <= ph_d;
		x_q   <= x_d;
		acc_q <= acc_d;
		hi_q  <= hi_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

endmodule

`default_nettype wire

### design/mersenne_twister_64_generator_top.sv
// Draw: one item at a time; the word passes through the state memory read register, the
// tempering register and the output register. A draw that finds the words exhausted
// first regenerates them word by word through the two-port state memory.
// Seed: word by word through the shared 32x32 multiplier.
// Reset clears the control state: the generator is unseeded and the index is exhausted.
// Top level of the 64-bit Mersenne Twister generator: request handling, index and output
// register. Depends on mt64_pkg and mt64_engine.
`default_nettype none

module mersenne_twister_64_generator_top
	import mt64_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	top_state_t       state_q, state_d;
	logic             seeded_q, seeded_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	rsp_t             res_q, res_d;
	rsp_t             rsp_q;
	logic             rsp_valid_q, rsp_valid_d;
	logic             load_rsp;
	logic             accept;
	eng_cmd_t         cmd;
	eng_sts_t         sts;

	mt64_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.seed   (req.seed_value),
		.sts    (sts)
	);

	assign req_stall = (state_q != T_IDLE);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d  = state_q;
		seeded_d = seeded_q;
		idx_d    = idx_q;
		res_d    = res_q;
		load_rsp = 1'b0;
		cmd.op   = ENG_NONE;
		cmd.addr = idx_q[ADDR_W-1:0];
		unique case (state_q)
			T_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_SEED) begin
						cmd.op  = ENG_SEED;
						state_d = T_SEED;
					end else if (!seeded_q) begin
						res_d.random_word = '0;
						res_d.unseeded    = 1'b1;
						state_d           = T_OUT;
					end else if (idx_q >= IDX_DEPTH) begin
						cmd.op  = ENG_TWIST;
						state_d = T_TWIST;
					end else begin
						state_d = T_RD_ISSUE;
					end
				end
			end
			T_SEED: begin
				if (sts.done) begin
					seeded_d = 1'b1;
					idx_d    = IDX_DEPTH;
					state_d  = T_IDLE;
				end
			end
			T_TWIST: begin
				if (sts.done) begin
					idx_d   = '0;
					state_d = T_RD_ISSUE;
				end
			end
			T_RD_ISSUE: begin
				cmd.op  = ENG_READ;
				state_d = T_READ;
			end
			T_READ: begin
				if (sts.done) begin
					res_d.random_word = temper(sts.rdata);
					res_d.unseeded    = 1'b0;
					idx_d             = idx_q + IDX_W'(1);
					state_d           = T_OUT;
				end
			end
			T_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = T_IDLE;
				end
			end
			default: begin
				state_d = T_IDLE;
			end
		endcase
	end

	always_comb begin
		if (load_rsp) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			seeded_q    <= 1'b0;
			idx_q       <= IDX_DEPTH;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			seeded_q    <= seeded_d;
			idx_q       <= idx_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### design/mt64_checker.sv
// Port-level checks for the 64-bit Mersenne Twister generator, bound to its top level.
// Depends on mt64_pkg and mersenne_twister_64_generator_top.
`default_nettype none

module mt64_checker
	import mt64_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// Every item keeps the block busy in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request side not stalled after an item was accepted");

	// A draw before seeding carries an all-zero word.
	a_unseeded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.unseeded) |-> (rsp.random_word == 64'd0))
		else $error("unseeded result with a non-zero word");

	// A new result only appears while the request side is busy with its item.
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without an item in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed or was dropped");

endmodule

bind mersenne_twister_64_generator_top mt64_checker u_mt64_checker (.*);

`default_nettype wire
